/* rtl/dccfb_pkg.sv */
// Shared types, constants and encode helpers for the command frame builder.
`default_nettype none
package dccfb_pkg;

  localparam int FrameW = 51;

  localparam logic [22:0] PreambleLong  = 23'h7FFFFF;
  localparam logic [13:0] PreambleShort = 14'h3FFF;
  localparam logic [7:0]  ExpansionCmd  = 8'hDE;
  localparam logic [4:0]  EstopCode     = 5'h11;
  localparam logic [2:0]  GroupOneHdr   = 3'b100;
  localparam logic [3:0]  GroupLowHdr   = 4'b1011;
  localparam logic [3:0]  GroupHighHdr  = 4'b1010;
  localparam logic [4:0]  MaxSpeedStep  = 5'd28;

  typedef enum logic [1:0] {
    OP_SPEED_FWD = 2'd0,
    OP_SPEED_REV = 2'd1,
    OP_FUNC_ON   = 2'd2,
    OP_FUNC_OFF  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    GRP_F0_F4,
    GRP_F5_F8,
    GRP_F9_F12,
    GRP_F13_F20,
    GRP_NONE
  } group_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] address;
    logic [4:0] speed_step;
    logic [4:0] function_index;
  } cmd_t;

  typedef struct packed {
    logic [4:0] group_one;
    logic [3:0] group_two_low;
    logic [3:0] group_two_high;
    logic [7:0] expansion;
  } func_img_t;

  function automatic group_e fn_group(input logic [4:0] fn);
    group_e g;
    if (fn <= 5'd4) g = GRP_F0_F4;
    else if (fn <= 5'd8) g = GRP_F5_F8;
    else if (fn <= 5'd12) g = GRP_F9_F12;
    else if (fn <= 5'd20) g = GRP_F13_F20;
    else g = GRP_NONE;
    return g;
  endfunction

  // bit position of a function inside its group image
  function automatic logic [2:0] fn_bit(input logic [4:0] fn);
    logic [4:0] b;
    if (fn == 5'd0) b = 5'd4;
    else if (fn <= 5'd4) b = fn - 5'd1;
    else if (fn <= 5'd8) b = fn - 5'd5;
    else if (fn <= 5'd12) b = fn - 5'd9;
    else b = fn - 5'd13;
    return b[2:0];
  endfunction

  // 28-step code: C bit from the low bit of step + 3, then the upper four bits
  function automatic logic [4:0] speed_code(input logic [4:0] step);
    logic [5:0] v;
    logic [4:0] c;
    v = {1'b0, step} + 6'd3;
    if (step == 5'd0) c = 5'd0;
    else if (step > MaxSpeedStep) c = EstopCode;
    else c = {v[0], v[4:1]};
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/dccfb_if.sv */
// Valid/ready channel interfaces for command requests and built frames.
`default_nettype none
interface dccfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] address;
  logic [4:0] speed_step;
  logic [4:0] function_index;

  modport source (output valid, op, address, speed_step, function_index, input ready);
  modport sink   (input valid, op, address, speed_step, function_index, output ready);
endinterface

interface dccfb_frame_if;
  logic        valid;
  logic        ready;
  logic [50:0] frame;

  modport source (output valid, frame, input ready);
  modport sink   (input valid, frame, output ready);
endinterface
`default_nettype wire

/* rtl/dcc_command_frame_builder_core.sv */
// Top level: request register, frame encode, function images and frame register.
// Builds one 51-bit track frame (bit 50 sent first) for every command item:
// speed/direction frames in the 28-step code, or function group frames for
// F0..F20, where F13..F20 go out as a two-byte expansion frame with a short
// preamble. Function on/off state is a single image shared by all addresses
// and clears to all-off on reset. One item per cycle is sustained; a request
// that is taken passes through the request register, then the frame
// register, and a stalled output only stops intake once both stages
// are full.
`default_nettype none
module dcc_command_frame_builder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  dccfb_cmd_if.sink          cmd_i,
  dccfb_frame_if.source      frame_o
);
  import dccfb_pkg::*;

  logic                in_vld_q;
  cmd_t                in_q;
  logic                out_vld_q;
  logic [FrameW-1:0]   frame_q;
  logic [FrameW-1:0]   frame_d;
  logic                advance;
  logic                take;
  func_img_t           img;

  assign advance     = in_vld_q && (!out_vld_q || frame_o.ready);
  assign cmd_i.ready = !in_vld_q || advance;
  assign take        = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= '{op: cmd_i.op, address: cmd_i.address,
                speed_step: cmd_i.speed_step, function_index: cmd_i.function_index};
    end
  end

  dccfb_func_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .op_i   (in_q.op),
    .fn_i   (in_q.function_index),
    .img_o  (img)
  );

  dccfb_encode u_encode (
    .cmd_i   (in_q),
    .img_i   (img),
    .frame_o (frame_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || frame_o.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      frame_q <= frame_d;
    end
  end

  assign frame_o.valid = out_vld_q;
  assign frame_o.frame = frame_q;

endmodule
`default_nettype wire

/* rtl/dccfb_func_state.sv */
// Function group images, updated by function on/off items.
`default_nettype none
module dccfb_func_state (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [1:0]            op_i,
  input  logic [4:0]            fn_i,
  output dccfb_pkg::func_img_t  img_o
);
  import dccfb_pkg::*;

  func_img_t img_q, img_d;
  logic      is_func;
  logic      on;
  logic [2:0] pos;

  assign is_func = (op_i == OP_FUNC_ON) || (op_i == OP_FUNC_OFF);
  assign on      = (op_i == OP_FUNC_ON);
  assign pos     = fn_bit(fn_i);

  always_comb begin
    img_d = img_q;
    if (is_func) begin
      case (fn_group(fn_i))
        GRP_F0_F4:   img_d.group_one[pos]            = on;
        GRP_F5_F8:   img_d.group_two_low[pos[1:0]]   = on;
        GRP_F9_F12:  img_d.group_two_high[pos[1:0]]  = on;
        GRP_F13_F20: img_d.expansion[pos]            = on;
        default:     img_d = img_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_q <= '0;
    end else if (en_i) begin
      img_q <= img_d;
    end
  end

  // frame carries the image after this item's update
  assign img_o = img_d;

endmodule
`default_nettype wire

/* rtl/dccfb_encode.sv */
// Data byte selection, check byte and frame assembly.
`default_nettype none
module dccfb_encode (
  input  dccfb_pkg::cmd_t               cmd_i,
  input  dccfb_pkg::func_img_t          img_i,
  output logic [dccfb_pkg::FrameW-1:0]  frame_o
);
  import dccfb_pkg::*;

  logic [7:0] data;
  logic [7:0] chk_single;
  logic [7:0] chk_double;
  logic       is_double;

  always_comb begin
    is_double = 1'b0;
    data      = {GroupOneHdr, img_i.group_one};
    case (op_e'(cmd_i.op))
      OP_SPEED_FWD: data = {3'b011, speed_code(cmd_i.speed_step)};
      OP_SPEED_REV: data = {3'b010, speed_code(cmd_i.speed_step)};
      OP_FUNC_ON, OP_FUNC_OFF: begin
        case (fn_group(cmd_i.function_index))
          GRP_F5_F8:   data = {GroupLowHdr, img_i.group_two_low};
          GRP_F9_F12:  data = {GroupHighHdr, img_i.group_two_high};
          GRP_F13_F20: begin
            is_double = 1'b1;
            data      = img_i.expansion;
          end
          default:     data = {GroupOneHdr, img_i.group_one};
        endcase
      end
      default: data = {GroupOneHdr, img_i.group_one};
    endcase
  end

  assign chk_single = cmd_i.address ^ data;
  assign chk_double = cmd_i.address ^ ExpansionCmd ^ data;

  assign frame_o = is_double
    ? {PreambleShort, 1'b0, cmd_i.address, 1'b0, ExpansionCmd, 1'b0, data,
       1'b0, chk_double, 1'b1}
    : {PreambleLong, 1'b0, cmd_i.address, 1'b0, data, 1'b0, chk_single, 1'b1};

endmodule
`default_nettype wire

/* tb/dcc_command_frame_builder_core_test.sv */
// Self-checking test of the command frame builder: random and directed items, frame scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module dcc_command_frame_builder_core_test;
  import dccfb_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int RandomItems = 950;
  localparam int IdlePct     = 23;

  logic clk_i;
  logic rst_ni;

  dccfb_cmd_if   cmd_if ();
  dccfb_frame_if frame_if ();

  dcc_command_frame_builder_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .frame_o (frame_if)
  );

  class frame_board;
    logic [4:0]  f0_f4;
    logic [3:0]  f5_f8;
    logic [3:0]  f9_f12;
    logic [7:0]  f13_f20;
    logic [50:0] pending_frames[$];
    int          errors;
    int          n_speed;
    int          n_group;
    int          n_expansion;
    int          n_out_of_range;

    function new();
      f0_f4 = '0;
      f5_f8 = '0;
      f9_f12 = '0;
      f13_f20 = '0;
      errors = 0;
      n_speed = 0;
      n_group = 0;
      n_expansion = 0;
      n_out_of_range = 0;
    endfunction

    function logic [50:0] short_frame(logic [7:0] addr, logic [7:0] data);
      logic [7:0] chk;
      chk = addr ^ data;
      return {PreambleLong, 1'b0, addr, 1'b0, data, 1'b0, chk, 1'b1};
    endfunction

    function logic [50:0] long_frame(logic [7:0] addr, logic [7:0] d1, logic [7:0] d2);
      logic [7:0] chk;
      chk = addr ^ d1 ^ d2;
      return {PreambleShort, 1'b0, addr, 1'b0, d1, 1'b0, d2, 1'b0, chk, 1'b1};
    endfunction

    function logic [4:0] step_code(logic [4:0] step);
      int v;
      logic [4:0] c;
      v = int'(step) + 3;
      if (step == 5'd0) c = 5'd0;
      else if (step > 5'd28) c = EstopCode;
      else c = {v[0], v[4:1]};
      return c;
    endfunction

    function void note_request(op_e op, logic [7:0] addr, logic [4:0] step, logic [4:0] fn);
      logic        on;
      logic [50:0] f;
      on = (op == OP_FUNC_ON);
      if (op == OP_SPEED_FWD || op == OP_SPEED_REV) begin
        f = short_frame(addr, {2'b01, op == OP_SPEED_FWD, step_code(step)});
        n_speed++;
      end else if (fn == 5'd0) begin
        f0_f4[4] = on;
        f = short_frame(addr, {GroupOneHdr, f0_f4});
        n_group++;
      end else if (fn <= 5'd4) begin
        f0_f4[fn - 5'd1] = on;
        f = short_frame(addr, {GroupOneHdr, f0_f4});
        n_group++;
      end else if (fn <= 5'd8) begin
        f5_f8[fn - 5'd5] = on;
        f = short_frame(addr, {GroupLowHdr, f5_f8});
        n_group++;
      end else if (fn <= 5'd12) begin
        f9_f12[fn - 5'd9] = on;
        f = short_frame(addr, {GroupHighHdr, f9_f12});
        n_group++;
      end else if (fn <= 5'd20) begin
        f13_f20[fn - 5'd13] = on;
        f = long_frame(addr, ExpansionCmd, f13_f20);
        n_expansion++;
      end else begin
        f = short_frame(addr, {GroupOneHdr, f0_f4});
        n_out_of_range++;
      end
      pending_frames.push_back(f);
    endfunction

    function void check_frame(logic [50:0] got);
      logic [50:0] want;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual %013h", $time, got);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (got !== want) begin
          $display("%0t: frame mismatch, expected %013h, actual %013h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  frame_board board;
  bit         send_idle;
  bit         recv_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_cmd(op_e op, logic [7:0] addr, logic [4:0] step, logic [4:0] fn);
    while (send_idle && $urandom_range(99) < IdlePct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid          <= 1'b1;
    cmd_if.op             <= op;
    cmd_if.address        <= addr;
    cmd_if.speed_step     <= step;
    cmd_if.function_index <= fn;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    board.note_request(op, addr, step, fn);
  endtask

  task automatic drain_frames();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_frames.size() != 0) @(posedge clk_i);
  endtask

  // frame sink
  initial begin
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && frame_if.valid && frame_if.ready) board.check_frame(frame_if.frame);
      frame_if.ready <= recv_idle ? ($urandom_range(99) >= IdlePct) : 1'b1;
    end
  end

  // stall watchdog
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (frame_if.valid && frame_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[dcc_command_frame_builder_core] ERROR");
    $finish;
  end

  initial begin
    op_e        op;
    logic [4:0] step;
    logic [4:0] fn;
    board = new();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    rst_ni <= 1'b0;
    cmd_if.valid          <= 1'b0;
    cmd_if.op             <= '0;
    cmd_if.address        <= '0;
    cmd_if.speed_step     <= '0;
    cmd_if.function_index <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: speed extremes, estop, out-of-range fields, every group edge
    send_cmd(OP_SPEED_FWD, 8'h00, 5'd0,  5'd0);
    send_cmd(OP_SPEED_FWD, 8'hFF, 5'd28, 5'd31);
    send_cmd(OP_SPEED_REV, 8'h01, 5'd1,  5'd0);
    send_cmd(OP_SPEED_REV, 8'h80, 5'd29, 5'd20);
    send_cmd(OP_SPEED_FWD, 8'h7F, 5'd31, 5'd31);
    send_cmd(OP_SPEED_REV, 8'hAA, 5'd30, 5'd13);
    send_cmd(OP_FUNC_ON,   8'h55, 5'd31, 5'd0);
    send_cmd(OP_FUNC_ON,   8'h03, 5'd0,  5'd1);
    send_cmd(OP_FUNC_ON,   8'h03, 5'd0,  5'd4);
    send_cmd(OP_FUNC_ON,   8'hFE, 5'd29, 5'd5);
    send_cmd(OP_FUNC_ON,   8'hFE, 5'd0,  5'd8);
    send_cmd(OP_FUNC_ON,   8'h10, 5'd0,  5'd9);
    send_cmd(OP_FUNC_ON,   8'h10, 5'd0,  5'd12);
    send_cmd(OP_FUNC_ON,   8'hDE, 5'd0,  5'd13);
    send_cmd(OP_FUNC_ON,   8'h00, 5'd31, 5'd20);
    send_cmd(OP_FUNC_ON,   8'hFF, 5'd0,  5'd21);
    send_cmd(OP_FUNC_OFF,  8'h21, 5'd0,  5'd31);
    send_cmd(OP_FUNC_OFF,  8'h42, 5'd0,  5'd0);
    send_cmd(OP_FUNC_OFF,  8'h42, 5'd0,  5'd4);
    send_cmd(OP_FUNC_OFF,  8'h84, 5'd0,  5'd8);
    send_cmd(OP_FUNC_OFF,  8'h84, 5'd0,  5'd12);
    send_cmd(OP_FUNC_OFF,  8'hC3, 5'd0,  5'd13);
    send_cmd(OP_FUNC_OFF,  8'hC3, 5'd31, 5'd20);
    drain_frames();

    for (int i = 0; i < RandomItems; i++) begin
      // long back-to-back stretch in the middle
      send_idle = !(i >= 300 && i < 560);
      recv_idle = send_idle;
      if (i == 600) drain_frames();
      op   = op_e'($urandom_range(3));
      step = ($urandom_range(99) < 80) ? 5'($urandom_range(29)) : 5'($urandom_range(31));
      fn   = ($urandom_range(99) < 85) ? 5'($urandom_range(20)) : 5'($urandom_range(31));
      send_cmd(op, 8'($urandom_range(255)), step, fn);
    end
    drain_frames();
    repeat (10) @(posedge clk_i);
    if (board.pending_frames.size() != 0) begin
      $display("%0t: %0d frames never arrived, expected 0, actual %0d", $time,
               board.pending_frames.size(), board.pending_frames.size());
      board.errors++;
    end

    $display("covered %0d speed, %0d group, %0d expansion, %0d out-of-range function items",
             board.n_speed, board.n_group, board.n_expansion, board.n_out_of_range);
    $display("with random stalls on both sides, a no-stall stretch and a full drain pause");
    if (board.errors == 0) begin
      $display("[dcc_command_frame_builder_core] OK");
    end else begin
      $display("[dcc_command_frame_builder_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/dccfb_pkg.sv
rtl/dccfb_if.sv
rtl/dccfb_func_state.sv
rtl/dccfb_encode.sv
rtl/dcc_command_frame_builder_core.sv
tb/dcc_command_frame_builder_core_test.sv
